[rtl/core/fte_pkg.sv]
package fte_pkg;

   localparam int PIXEL_INDEX_W = 6;
   localparam int NOW_W         = 32;
   localparam int LEVEL_W       = 8;
   localparam int WORD_W        = 15;
   localparam int INTERVAL_W    = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int STORE_LIMIT   = 2 ** PIXEL_INDEX_W;

   // level difference (9 bit signed) times elapsed time (32 bit signed)
   localparam int PRODUCT_W = LEVEL_W + 1 + NOW_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_INTERVAL = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INTERVAL = CSR_INDEX_W'(1);

   localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 16'd500;
   localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RESET = 16'd3000;
   localparam logic [LEVEL_W-1:0]    LEVEL_MAX          = 8'd255;

   typedef struct packed {
      logic                     in_range;
      logic [PIXEL_INDEX_W-1:0] pixel_index;
      logic [NOW_W-1:0]         now_ms;
      logic [LEVEL_W-1:0]       random_brightness;
      logic [WORD_W-1:0]        random_word;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] target_level;
      logic [NOW_W-1:0]   target_time;
      logic [LEVEL_W-1:0] start_level;
      logic [NOW_W-1:0]   start_time;
      logic [LEVEL_W-1:0] shown_level;
   } pixel_entry_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] min_interval_ms;
      logic [INTERVAL_W-1:0] max_interval_ms;
   } interval_cfg_type;

   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] brightness;
      logic               retargeted;
   } result_type;

   typedef struct packed {
      logic                 done;
      logic [PRODUCT_W-1:0] quotient;
      logic [NOW_W-1:0]     remainder;
   } div_result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EVAL,
      BK_MUL,
      BK_LAUNCH,
      BK_DIV,
      BK_FIN
   } back_state_type;

endpackage

[rtl/core/fte_ram.sv]
module fte_ram
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 64,
      localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
      input  logic              clock,
      input  logic              wr_en,
      input  logic [ADDR_W-1:0] wr_addr,
      input  logic [WIDTH-1:0]  wr_data,
      input  logic              rd_en,
      input  logic [ADDR_W-1:0] rd_addr,
      output logic [WIDTH-1:0]  rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/fte_div.sv]
module fte_div
   import fte_pkg::*;
   (
      input  logic                 clock,
      input  logic                 reset,
      input  logic                 start,
      input  logic [PRODUCT_W-1:0] dividend,
      input  logic [NOW_W-1:0]     divisor,
      output div_result_type       result
   );

   localparam int COUNT_W = $clog2(PRODUCT_W + 1);

   // restoring divider, one quotient bit per cycle
   logic [PRODUCT_W-1:0] dvd_ff, dvd_in;
   logic [NOW_W-1:0]     rem_ff, rem_in;
   logic [NOW_W-1:0]     divisor_ff, divisor_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NOW_W+1:0]     trial;
   logic                 qbit;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      trial      = {1'b0, rem_ff, dvd_ff[PRODUCT_W-1]} - {2'b00, divisor_ff};
      qbit       = ~trial[NOW_W+1];
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         dvd_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = COUNT_W'(PRODUCT_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (qbit) begin
            rem_in = trial[NOW_W-1:0];
         end else begin
            rem_in = {rem_ff[NOW_W-2:0], dvd_ff[PRODUCT_W-1]};
         end
         dvd_in   = {dvd_ff[PRODUCT_W-2:0], qbit};
         count_in = count_ff - COUNT_W'(1);
         if (count_ff == COUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = dvd_ff;
   assign result.remainder = rem_ff;

endmodule

[rtl/core/fte_front.sv]
module fte_front
   import fte_pkg::*;
   #(
      parameter int DEPTH = 64
   )
   (
      input  logic                     clock,
      input  logic                     reset,
      input  logic                     start,
      output logic                     busy,
      input  logic [PIXEL_INDEX_W-1:0] pixel_index,
      input  logic [NOW_W-1:0]         now_ms,
      input  logic [LEVEL_W-1:0]       random_brightness,
      input  logic [WORD_W-1:0]        random_word,
      output logic                     q_valid,
      output item_type                 q_item,
      input  logic                     q_pop
   );

   // two-entry queue towards the back end
   item_type   slots_ff [2];
   item_type   slots_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   incoming;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      slots_ff <= slots_in;
   end

   always_comb begin
      incoming.in_range          = ({1'b0, pixel_index} < (PIXEL_INDEX_W + 1)'(DEPTH));
      incoming.pixel_index       = pixel_index;
      incoming.now_ms            = now_ms;
      incoming.random_brightness = random_brightness;
      incoming.random_word       = random_word;

      push      = start && !busy;
      slots_in  = slots_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         slots_in[wr_ptr_ff] = incoming;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   assign busy    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slots_ff[rd_ptr_ff];

endmodule

[rtl/core/fte_back.sv]
module fte_back
   import fte_pkg::*;
   #(
      parameter int DEPTH = 64,
      localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
      input  logic             clock,
      input  logic             reset,
      input  interval_cfg_type cfg,
      input  logic             q_valid,
      input  item_type         q_item,
      output logic             q_pop,
      output result_type       rsp
   );

   localparam int ENTRY_W = $bits(pixel_entry_type);
   localparam int SUM_W   = PRODUCT_W + 1;

   back_state_type state_ff, state_in;
   item_type        item_ff, item_in;
   pixel_entry_type entry_ff, entry_in;
   logic            fade_ff, fade_in;     // target time still ahead
   logic            slope_ff, slope_in;   // positive fade span
   logic signed [PRODUCT_W-1:0] product_ff, product_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   result_type      rsp_ff, rsp_in;

   logic [ADDR_W-1:0] addr;
   logic              ram_rd_en;
   logic              ram_wr_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   pixel_entry_type   entry_now;
   pixel_entry_type   entry_new;

   logic [NOW_W-1:0]  ahead;
   logic [NOW_W-1:0]  span;
   logic signed [LEVEL_W:0]   diff;
   logic signed [NOW_W-1:0]   elapsed;
   logic signed [INTERVAL_W:0] ispan;
   logic [INTERVAL_W-1:0]     ispan_safe;

   logic                 div_start;
   logic [PRODUCT_W-1:0] div_dividend;
   logic [NOW_W-1:0]     div_divisor;
   div_result_type       div_res;

   logic signed [SUM_W-1:0] quot_signed;
   logic signed [SUM_W-1:0] level_sum;
   logic [LEVEL_W-1:0]      level;

   fte_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (item_ff.pixel_index[ADDR_W-1:0]),
      .wr_data (entry_new),
      .rd_en   (ram_rd_en),
      .rd_addr (q_item.pixel_index[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   fte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_ff   <= rsp_in;
      end
      item_ff    <= item_in;
      entry_ff   <= entry_in;
      fade_ff    <= fade_in;
      slope_ff   <= slope_in;
      product_ff <= product_in;
   end

   always_comb begin
      addr      = item_ff.pixel_index[ADDR_W-1:0];
      // unwritten entries read as all zeros
      entry_now = valid_ff[addr] ? pixel_entry_type'(ram_rd_data) : '0;

      ahead   = entry_now.target_time - item_ff.now_ms;
      span    = entry_ff.target_time - entry_ff.start_time;
      diff    = $signed({1'b0, entry_ff.target_level}) - $signed({1'b0, entry_ff.start_level});
      elapsed = $signed(item_ff.now_ms - entry_ff.start_time);

      ispan      = $signed({1'b0, cfg.max_interval_ms}) - $signed({1'b0, cfg.min_interval_ms});
      ispan_safe = (ispan[INTERVAL_W] || (ispan == '0)) ? INTERVAL_W'(1) : ispan[INTERVAL_W-1:0];

      // floor division from magnitude quotient
      quot_signed = product_ff[PRODUCT_W-1]
                  ? -($signed({1'b0, div_res.quotient}) + SUM_W'(div_res.remainder != '0))
                  : $signed({1'b0, div_res.quotient});
      level_sum   = quot_signed + $signed(SUM_W'(entry_ff.start_level));
      if (level_sum[SUM_W-1]) begin
         level = '0;
      end else if (level_sum > $signed(SUM_W'(LEVEL_MAX))) begin
         level = LEVEL_MAX;
      end else begin
         level = level_sum[LEVEL_W-1:0];
      end

      state_in     = state_ff;
      item_in      = item_ff;
      entry_in     = entry_ff;
      fade_in      = fade_ff;
      slope_in     = slope_ff;
      product_in   = product_ff;
      valid_in     = valid_ff;
      rsp_in       = '0;
      q_pop        = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      entry_new    = entry_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               ram_rd_en = q_item.in_range;
               state_in  = q_item.in_range ? BK_EVAL : BK_FIN;
            end
         end
         BK_EVAL: begin
            entry_in = entry_now;
            fade_in  = !ahead[NOW_W-1] && (ahead != '0);
            slope_in = 1'b0;
            if (!(!ahead[NOW_W-1] && (ahead != '0))) begin
               state_in = BK_LAUNCH;
            end else begin
               span     = entry_now.target_time - entry_now.start_time;
               slope_in = !span[NOW_W-1] && (span != '0);
               state_in = (!span[NOW_W-1] && (span != '0)) ? BK_MUL : BK_FIN;
            end
         end
         BK_MUL: begin
            product_in = diff * elapsed;
            state_in   = BK_LAUNCH;
         end
         BK_LAUNCH: begin
            div_start = 1'b1;
            if (fade_ff) begin
               div_dividend = product_ff[PRODUCT_W-1] ? PRODUCT_W'(-product_ff)
                                                      : PRODUCT_W'(product_ff);
               div_divisor  = span;
            end else begin
               div_dividend = PRODUCT_W'(item_ff.random_word);
               div_divisor  = NOW_W'(ispan_safe);
            end
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (div_res.done) begin
               state_in = BK_FIN;
            end
         end
         BK_FIN: begin
            rsp_in.valid = 1'b1;
            if (item_ff.in_range) begin
               ram_wr_en      = 1'b1;
               valid_in[addr] = 1'b1;
               if (fade_ff) begin
                  entry_new.shown_level = slope_ff ? level : entry_ff.target_level;
                  rsp_in.brightness     = entry_new.shown_level;
               end else begin
                  entry_new.start_level  = entry_ff.target_level;
                  entry_new.start_time   = entry_ff.target_time;
                  entry_new.target_level = item_ff.random_brightness;
                  entry_new.target_time  = item_ff.now_ms + NOW_W'(cfg.min_interval_ms)
                                         + NOW_W'(div_res.remainder[INTERVAL_W-1:0]);
                  rsp_in.brightness      = entry_ff.shown_level;
                  rsp_in.retargeted      = 1'b1;
               end
            end
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp = rsp_ff;

endmodule

[rtl/core/led_twinkle_fade_engine_top.sv]
// LED twinkle fade engine. Each transfer on the req_ ports refreshes its pixel if in range
// and yields exactly one result, strobed on rsp_valid for a single cycle; results cannot
// be held off, so take them as they come. Results leave in the order items were taken.
// An item for a fading pixel with a positive span goes through eval, mul, launch, the
// 41-step serial divider doing the floor division, and fin; a retarget skips mul but
// uses that divider for the modulo; a fade with no positive span goes from eval to fin,
// and an out-of-range pixel from idle to fin. A two-entry queue sits in front, so busy
// rises only once two items are waiting behind the one being worked on. Write min/max
// interval only while idle. Pixel state lives in a RAM; per-pixel valid
// bits make untouched pixels read as zero straight out of reset, no clearing pass.
module led_twinkle_fade_engine_top
   import fte_pkg::*;
   #(
      parameter int NUM_PIXELS = 64
   )
   (
      input  logic                     clock,
      input  logic                     reset,
      // item transfer
      input  logic                     start,
      output logic                     busy,
      input  logic [PIXEL_INDEX_W-1:0] req_pixel_index,
      input  logic [NOW_W-1:0]         req_now_ms,
      input  logic [LEVEL_W-1:0]       req_random_brightness,
      input  logic [WORD_W-1:0]        req_random_word,
      // result transfer
      output logic                     rsp_valid,
      output logic [LEVEL_W-1:0]       rsp_brightness,
      output logic                     rsp_retargeted,
      // register writes
      input  logic                     csr_write_enable,
      input  logic [CSR_INDEX_W-1:0]   csr_index,
      input  logic [INTERVAL_W-1:0]    csr_write_data
   );

   // the index field caps how many pixels can be stored
   localparam int DEPTH = (NUM_PIXELS < STORE_LIMIT) ? NUM_PIXELS : STORE_LIMIT;

   interval_cfg_type cfg_ff, cfg_in;
   logic             q_valid;
   item_type         q_item;
   logic             q_pop;
   result_type       rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval_ms <= MIN_INTERVAL_RESET;
         cfg_ff.max_interval_ms <= MAX_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_INTERVAL: cfg_in.min_interval_ms = csr_write_data;
            CSR_MAX_INTERVAL: cfg_in.max_interval_ms = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // front: takes and classifies items, queues them
   fte_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .pixel_index       (req_pixel_index),
      .now_ms            (req_now_ms),
      .random_brightness (req_random_brightness),
      .random_word       (req_random_word),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // back: pixel store, fade arithmetic, retargeting
   fte_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

   assign rsp_valid      = rsp.valid;
   assign rsp_brightness = rsp.brightness;
   assign rsp_retargeted = rsp.retargeted;

`ifndef SYNTHESIS
   // back end always passes through idle between results
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   // queue only fills through an accepted transfer
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without a transfer");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("state not cleared by reset");
`endif

endmodule
